// ----- rtl/ale_pkg.sv -----
// array list engine: shared types and codes
// command and result beat layouts, command and status codes; no dependencies
package ale_pkg;

    localparam int VAL_W = 32;
    localparam int IDX_W = 8;

    localparam logic [3:0] CMD_INS_FRONT = 4'd0;
    localparam logic [3:0] CMD_INS_END   = 4'd1;
    localparam logic [3:0] CMD_INS_POS   = 4'd2;
    localparam logic [3:0] CMD_DEL_FRONT = 4'd3;
    localparam logic [3:0] CMD_DEL_END   = 4'd4;
    localparam logic [3:0] CMD_DEL_POS   = 4'd5;
    localparam logic [3:0] CMD_SEARCH    = 4'd6;
    localparam logic [3:0] CMD_LIST      = 4'd7;
    localparam logic [3:0] CMD_ROTATE    = 4'd8;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_RANGE   = 3'd3;
    localparam logic [2:0] ST_ROT_REF = 3'd4;

    typedef struct packed {
        logic [3:0]              cmd;
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        position;
        logic [IDX_W-1:0]        rotate_amount;
    } ale_cmd_t;

    typedef struct packed {
        logic [2:0]              status;
        logic signed [VAL_W-1:0] item_value;
        logic [IDX_W-1:0]        item_index;
        logic [IDX_W-1:0]        match_count;
        logic                    last;
    } ale_res_t;

endpackage

// ----- rtl/ale_cmd_if.sv -----
// command channel: valid/ready with one command beat
// depends on ale_pkg
interface ale_cmd_if;
    logic              valid;
    logic              ready;
    ale_pkg::ale_cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ale_res_if.sv -----
// result channel: valid/ready with one result beat
// depends on ale_pkg
interface ale_res_if;
    logic              valid;
    logic              ready;
    ale_pkg::ale_res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ale_store.sv -----
// entry store: one write port, one read port with registered read data
// depends on ale_pkg for the data width
module ale_store #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [ADDR_W-1:0]                waddr,
    input  logic [ale_pkg::VAL_W-1:0]        wdata,
    input  logic                             re,
    input  logic [ADDR_W-1:0]                raddr,
    output logic [ale_pkg::VAL_W-1:0]        rdata
);

    logic [ale_pkg::VAL_W-1:0] mem [DEPTH];
    logic [ale_pkg::VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/array_list_engine_core.sv -----
// Ordered list of up to CAPACITY signed 32-bit values, kept packed in a single-port-read,
// single-port-write store and walked one entry at a time by a small sequencer. A command
// is taken only while the engine is idle. Every entry visit is a read, then a use or a
// write back. Insert moves the entries from the landing index up, delete moves the later
// entries down, list and rotated view read every entry, and search reads every entry once
// and, with any match, again up to the last match. Results pass through the result register.
// A result waiting to be taken stalls only the step that emits the next one.
// depends on ale_pkg, ale_cmd_if, ale_res_if, ale_store
module array_list_engine_core #(
    parameter int CAPACITY = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    ale_cmd_if.sink   req,
    ale_res_if.source rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SHUP_RD   = 4'd1;
    localparam logic [3:0] S_SHUP_WR   = 4'd2;
    localparam logic [3:0] S_INS_WR    = 4'd3;
    localparam logic [3:0] S_DEL_RD    = 4'd4;
    localparam logic [3:0] S_DEL_CAP   = 4'd5;
    localparam logic [3:0] S_SHDN_RD   = 4'd6;
    localparam logic [3:0] S_SHDN_WR   = 4'd7;
    localparam logic [3:0] S_CNT_RD    = 4'd8;
    localparam logic [3:0] S_CNT_CHK   = 4'd9;
    localparam logic [3:0] S_SCAN_RD   = 4'd10;
    localparam logic [3:0] S_SCAN_CHK  = 4'd11;
    localparam logic [3:0] S_WALK_RD   = 4'd12;
    localparam logic [3:0] S_WALK_EMIT = 4'd13;
    localparam logic [3:0] S_EMIT      = 4'd14;

    logic [3:0]                state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             ptr_reg, ptr_next;
    logic [CW-1:0]             idx_reg, idx_next;
    logic [CW-1:0]             rot_reg, rot_next;
    logic [CW-1:0]             total_reg, total_next;
    logic [CW-1:0]             seen_reg, seen_next;
    logic [ale_pkg::VAL_W-1:0] key_reg, key_next;
    logic [2:0]                pend_status_reg, pend_status_next;
    logic [ale_pkg::VAL_W-1:0] pend_value_reg, pend_value_next;

    logic                      out_valid_reg, out_valid_next;
    ale_pkg::ale_res_t         out_data_reg;

    logic                      emit;
    ale_pkg::ale_res_t         emit_data;
    logic                      emit_ok;

    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [ale_pkg::VAL_W-1:0] mem_wdata;
    logic                      mem_re;
    logic [AW-1:0]             mem_raddr;
    logic [ale_pkg::VAL_W-1:0] mem_rdata;

    ale_pkg::ale_cmd_t         cmd_beat;
    logic [8:0]                pos9;
    logic [8:0]                rot9;
    logic [8:0]                n9;
    logic                      list_full;
    logic                      list_empty;
    logic [CW-1:0]             ptr_inc;
    logic [CW-1:0]             walk_src;
    logic [CW-1:0]             seen_inc;
    logic                      hit;

    ale_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cmd_beat   = req.data;
    assign pos9       = {1'b0, cmd_beat.position};
    assign rot9       = {1'b0, cmd_beat.rotate_amount};
    assign n9         = 9'(count_reg);
    assign list_full  = (count_reg == CW'(CAPACITY));
    assign list_empty = (count_reg == '0);
    assign ptr_inc    = ptr_reg + CW'(1);
    assign seen_inc   = seen_reg + CW'(1);
    assign hit        = (mem_rdata == key_reg);
    // right-rotated view: slot i shows entry (i - rot) mod n
    assign walk_src   = (ptr_reg >= rot_reg) ? (ptr_reg - rot_reg)
                                             : (ptr_reg + count_reg - rot_reg);
    assign emit_ok    = !out_valid_reg || rsp.ready;

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.data   = out_data_reg;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        idx_next         = idx_reg;
        rot_next         = rot_reg;
        total_next       = total_reg;
        seen_next        = seen_reg;
        key_next         = key_reg;
        pend_status_next = pend_status_reg;
        pend_value_next  = pend_value_reg;
        emit             = 1'b0;
        emit_data        = '0;
        mem_we           = 1'b0;
        mem_waddr        = ptr_reg[AW-1:0];
        mem_wdata        = mem_rdata;
        mem_re           = 1'b0;
        mem_raddr        = ptr_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next         = cmd_beat.value;
                    pend_value_next  = '0;
                    pend_status_next = ale_pkg::ST_OK;
                    ptr_next         = count_reg;
                    rot_next         = '0;
                    unique case (cmd_beat.cmd) inside
                        ale_pkg::CMD_INS_FRONT, ale_pkg::CMD_INS_END,
                        ale_pkg::CMD_INS_POS:
                        begin
                            state_next = S_SHUP_RD;
                            if (cmd_beat.cmd == ale_pkg::CMD_INS_FRONT)
                            begin
                                idx_next = '0;
                            end
                            else if (cmd_beat.cmd == ale_pkg::CMD_INS_END)
                            begin
                                idx_next = count_reg;
                            end
                            else if (list_empty || pos9 == 9'd1)
                            begin
                                idx_next = '0;
                            end
                            else if (pos9 == 9'd0 || pos9 > n9 + 9'd1)
                            begin
                                pend_status_next = ale_pkg::ST_RANGE;
                                state_next       = S_EMIT;
                            end
                            else
                            begin
                                idx_next = CW'(pos9 - 9'd1);
                            end
                            if (state_next == S_SHUP_RD && list_full)
                            begin
                                pend_status_next = ale_pkg::ST_FULL;
                                state_next       = S_EMIT;
                            end
                        end
                        ale_pkg::CMD_DEL_FRONT, ale_pkg::CMD_DEL_END,
                        ale_pkg::CMD_DEL_POS:
                        begin
                            state_next = S_DEL_RD;
                            if (cmd_beat.cmd == ale_pkg::CMD_DEL_FRONT)
                            begin
                                idx_next = '0;
                            end
                            else if (cmd_beat.cmd == ale_pkg::CMD_DEL_END)
                            begin
                                idx_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                idx_next = CW'(pos9 - 9'd1);
                            end
                            if (list_empty)
                            begin
                                pend_status_next = ale_pkg::ST_EMPTY;
                                state_next       = S_EMIT;
                            end
                            else if (cmd_beat.cmd == ale_pkg::CMD_DEL_POS &&
                                     (pos9 == 9'd0 || pos9 > n9))
                            begin
                                pend_status_next = ale_pkg::ST_RANGE;
                                state_next       = S_EMIT;
                            end
                        end
                        ale_pkg::CMD_SEARCH:
                        begin
                            ptr_next   = '0;
                            total_next = '0;
                            state_next = S_CNT_RD;
                        end
                        ale_pkg::CMD_LIST:
                        begin
                            ptr_next = '0;
                            if (list_empty)
                            begin
                                pend_status_next = ale_pkg::ST_EMPTY;
                                state_next       = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_WALK_RD;
                            end
                        end
                        ale_pkg::CMD_ROTATE:
                        begin
                            ptr_next = '0;
                            rot_next = CW'(rot9);
                            if (n9 < 9'd2 || rot9 >= n9)
                            begin
                                pend_status_next = ale_pkg::ST_ROT_REF;
                                state_next       = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_WALK_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // open a gap at idx by moving entries up, top first
            S_SHUP_RD:
            begin
                if (ptr_reg > idx_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_reg[AW-1:0] - AW'(1);
                    state_next = S_SHUP_WR;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end

            S_SHUP_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg[AW-1:0];
                mem_wdata  = mem_rdata;
                ptr_next   = ptr_reg - CW'(1);
                state_next = S_SHUP_RD;
            end

            S_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0];
                mem_wdata  = key_reg;
                count_next = count_reg + CW'(1);
                state_next = S_EMIT;
            end

            S_DEL_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg[AW-1:0];
                ptr_next   = idx_reg;
                state_next = S_DEL_CAP;
            end

            S_DEL_CAP:
            begin
                pend_value_next = mem_rdata;
                state_next      = S_SHDN_RD;
            end

            // close the gap by moving later entries down
            S_SHDN_RD:
            begin
                if (ptr_inc < count_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_inc[AW-1:0];
                    state_next = S_SHDN_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_EMIT;
                end
            end

            S_SHDN_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg[AW-1:0];
                mem_wdata  = mem_rdata;
                ptr_next   = ptr_inc;
                state_next = S_SHDN_RD;
            end

            // first pass counts matches so the final one can carry last
            S_CNT_RD:
            begin
                if (ptr_reg < count_reg)
                begin
                    mem_re     = 1'b1;
                    state_next = S_CNT_CHK;
                end
                else if (total_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    ptr_next   = '0;
                    seen_next  = '0;
                    state_next = S_SCAN_RD;
                end
            end

            S_CNT_CHK:
            begin
                if (hit)
                begin
                    total_next = total_reg + CW'(1);
                end
                ptr_next   = ptr_inc;
                state_next = S_CNT_RD;
            end

            S_SCAN_RD:
            begin
                if (ptr_reg < count_reg)
                begin
                    mem_re     = 1'b1;
                    state_next = S_SCAN_CHK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_SCAN_CHK:
            begin
                if (!hit)
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_SCAN_RD;
                end
                else if (emit_ok)
                begin
                    emit                  = 1'b1;
                    emit_data.status      = ale_pkg::ST_OK;
                    emit_data.item_value  = key_reg;
                    emit_data.item_index  = ale_pkg::IDX_W'(ptr_reg);
                    emit_data.match_count = ale_pkg::IDX_W'(seen_inc);
                    emit_data.last        = (seen_inc == total_reg);
                    seen_next             = seen_inc;
                    ptr_next              = ptr_inc;
                    state_next            = (seen_inc == total_reg) ? S_IDLE : S_SCAN_RD;
                end
            end

            S_WALK_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = walk_src[AW-1:0];
                state_next = S_WALK_EMIT;
            end

            S_WALK_EMIT:
            begin
                if (emit_ok)
                begin
                    emit                 = 1'b1;
                    emit_data.status     = ale_pkg::ST_OK;
                    emit_data.item_value = mem_rdata;
                    emit_data.item_index = ale_pkg::IDX_W'(ptr_reg);
                    emit_data.last       = (ptr_inc == count_reg);
                    ptr_next             = ptr_inc;
                    state_next           = (ptr_inc == count_reg) ? S_IDLE : S_WALK_RD;
                end
            end

            S_EMIT:
            begin
                if (emit_ok)
                begin
                    emit                 = 1'b1;
                    emit_data.status     = pend_status_reg;
                    emit_data.item_value = pend_value_reg;
                    emit_data.last       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = emit || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg         <= ptr_next;
        idx_reg         <= idx_next;
        rot_reg         <= rot_next;
        total_reg       <= total_next;
        seen_reg        <= seen_next;
        key_reg         <= key_next;
        pend_status_reg <= pend_status_next;
        pend_value_reg  <= pend_value_next;
        if (emit)
        begin
            out_data_reg <= emit_data;
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for array_list_engine_core: random and directed list commands
// with a shadow list that predicts every result beat; depends on ale_pkg, ale_cmd_if,
// ale_res_if and the engine rtl
module tb_top;

    localparam int CAP         = 8;
    localparam int RAND_ITEMS  = 460;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 60;

    // command codes the engine ignores
    localparam logic [3:0] CMD_FIRST_UNUSED = 4'd9;
    localparam logic [3:0] CMD_LAST_UNUSED  = 4'd15;

    logic clk;
    logic rst_n;

    ale_cmd_if req_ch ();
    ale_res_if rsp_ch ();

    array_list_engine_core #(
        .CAPACITY (CAP)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the list, advanced on every accepted command beat
    logic signed [ale_pkg::VAL_W-1:0] shadow_list [CAP];
    int                               shadow_len;
    ale_pkg::ale_res_t                owed_results [$];

    ale_pkg::ale_cmd_t pending_cmds [$];
    int                queued_total;
    int                accepted_total;
    int                plan_len;

    int cycle_count;
    int mismatches;
    int beats_checked;
    int send_gap;
    int hold_off;
    int n_ins, n_del, n_search, n_list, n_rot, n_ignored;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // gap lengths: mostly none or short, a few long, and quiet windows with none
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((cycle_count % 2048) < 300) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [2:0] shadow_insert(int at,
                                                 logic signed [ale_pkg::VAL_W-1:0] v);
        if (shadow_len >= CAP) return ale_pkg::ST_FULL;
        if (at > shadow_len) at = shadow_len;
        for (int i = shadow_len; i > at; i--) shadow_list[i] = shadow_list[i-1];
        shadow_list[at] = v;
        shadow_len++;
        return ale_pkg::ST_OK;
    endfunction

    function automatic logic signed [ale_pkg::VAL_W-1:0] shadow_remove(int at);
        logic signed [ale_pkg::VAL_W-1:0] v;
        v = shadow_list[at];
        for (int i = at; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
        shadow_len--;
        return v;
    endfunction

    function automatic void owe(logic [2:0] st, logic signed [ale_pkg::VAL_W-1:0] v,
                                int idx, int cnt, bit lst);
        ale_pkg::ale_res_t r;
        r.status      = st;
        r.item_value  = v;
        r.item_index  = ale_pkg::IDX_W'(idx);
        r.match_count = ale_pkg::IDX_W'(cnt);
        r.last        = lst;
        owed_results.push_back(r);
    endfunction

    // works out the result beats one command produces and updates the shadow list
    task automatic apply_command(input ale_pkg::ale_cmd_t c);
        int n;
        int total;
        int seen;
        int rot;
        n     = shadow_len;
        total = 0;
        seen  = 0;
        rot   = c.rotate_amount;
        case (c.cmd) inside
            ale_pkg::CMD_INS_FRONT:
            begin
                n_ins++;
                owe(shadow_insert(0, c.value), 0, 0, 0, 1'b1);
            end
            ale_pkg::CMD_INS_END:
            begin
                n_ins++;
                owe(shadow_insert(n, c.value), 0, 0, 0, 1'b1);
            end
            ale_pkg::CMD_INS_POS:
            begin
                n_ins++;
                // empty list or position one go to the front before any range check
                if (n == 0 || c.position == 1)
                    owe(shadow_insert(0, c.value), 0, 0, 0, 1'b1);
                else if (c.position == 0 || c.position > n + 1)
                    owe(ale_pkg::ST_RANGE, 0, 0, 0, 1'b1);
                else
                    owe(shadow_insert(c.position - 1, c.value), 0, 0, 0, 1'b1);
            end
            ale_pkg::CMD_DEL_FRONT, ale_pkg::CMD_DEL_END, ale_pkg::CMD_DEL_POS:
            begin
                n_del++;
                if (n == 0)
                    owe(ale_pkg::ST_EMPTY, 0, 0, 0, 1'b1);
                else if (c.cmd == ale_pkg::CMD_DEL_FRONT)
                    owe(ale_pkg::ST_OK, shadow_remove(0), 0, 0, 1'b1);
                else if (c.cmd == ale_pkg::CMD_DEL_END)
                    owe(ale_pkg::ST_OK, shadow_remove(n - 1), 0, 0, 1'b1);
                else if (c.position == 0 || c.position > n)
                    owe(ale_pkg::ST_RANGE, 0, 0, 0, 1'b1);
                else
                    owe(ale_pkg::ST_OK, shadow_remove(c.position - 1), 0, 0, 1'b1);
            end
            ale_pkg::CMD_SEARCH:
            begin
                n_search++;
                for (int i = 0; i < n; i++)
                    if (shadow_list[i] == c.value) total++;
                if (total == 0)
                    owe(ale_pkg::ST_OK, 0, 0, 0, 1'b1);
                for (int i = 0; i < n; i++)
                begin
                    if (shadow_list[i] == c.value)
                    begin
                        seen++;
                        owe(ale_pkg::ST_OK, c.value, i, seen, seen == total);
                    end
                end
            end
            ale_pkg::CMD_LIST:
            begin
                n_list++;
                if (n == 0)
                    owe(ale_pkg::ST_EMPTY, 0, 0, 0, 1'b1);
                for (int i = 0; i < n; i++)
                    owe(ale_pkg::ST_OK, shadow_list[i], i, 0, i + 1 == n);
            end
            ale_pkg::CMD_ROTATE:
            begin
                n_rot++;
                if (n < 2 || rot > n - 1)
                    owe(ale_pkg::ST_ROT_REF, 0, 0, 0, 1'b1);
                else
                    for (int i = 0; i < n; i++)
                        owe(ale_pkg::ST_OK, shadow_list[(i + n - rot) % n], i, 0,
                            i + 1 == n);
            end
            default:
                n_ignored++;
        endcase
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        $display("mismatch: %s at result beat %0d, got %h, expected %h",
                 what, beats_checked, got, want);
    endtask

    task automatic check_beat(input ale_pkg::ale_res_t got);
        ale_pkg::ale_res_t want;
        if (owed_results.size() == 0)
        begin
            flag_mismatch("unexpected beat", got.item_value, 0);
        end
        else
        begin
            want = owed_results.pop_front();
            if (got.status !== want.status)
                flag_mismatch("status", got.status, want.status);
            if (got.item_value !== want.item_value)
                flag_mismatch("item_value", got.item_value, want.item_value);
            if (got.item_index !== want.item_index)
                flag_mismatch("item_index", got.item_index, want.item_index);
            if (got.match_count !== want.match_count)
                flag_mismatch("match_count", got.match_count, want.match_count);
            if (got.last !== want.last)
                flag_mismatch("last", got.last, want.last);
        end
        beats_checked++;
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                apply_command(req_ch.data);
                accepted_total++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.data  <= pending_cmds.pop_front();
                    send_gap = pick_gap();
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_off = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                check_beat(rsp_ch.data);
            if (hold_off > 0)
            begin
                hold_off--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 30) hold_off = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still owed",
                     cycle_count, owed_results.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // list length the generator expects once a command has gone through
    function automatic int planned_len_after(logic [3:0] op, int pos, int n);
        case (op) inside
            ale_pkg::CMD_INS_FRONT, ale_pkg::CMD_INS_END:
                return (n < CAP) ? n + 1 : n;
            ale_pkg::CMD_INS_POS:
                if (n != 0 && pos != 1 && (pos == 0 || pos > n + 1)) return n;
                else return (n < CAP) ? n + 1 : n;
            ale_pkg::CMD_DEL_FRONT, ale_pkg::CMD_DEL_END:
                return (n > 0) ? n - 1 : 0;
            ale_pkg::CMD_DEL_POS:
                return (n == 0 || pos == 0 || pos > n) ? n : n - 1;
            default:
                return n;
        endcase
    endfunction

    task automatic queue_cmd(input logic [3:0] op,
                             input logic signed [ale_pkg::VAL_W-1:0] v,
                             input int pos, input int rot);
        ale_pkg::ale_cmd_t c;
        c.cmd           = op;
        c.value         = v;
        c.position      = ale_pkg::IDX_W'(pos);
        c.rotate_amount = ale_pkg::IDX_W'(rot);
        pending_cmds.push_back(c);
        queued_total++;
        plan_len = planned_len_after(op, pos, plan_len);
    endtask

    task automatic wait_drained();
        while (!(accepted_total == queued_total && owed_results.size() == 0))
            @(posedge clk);
        // an ignored command owes no result beat to wait for
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // small pool so searches find matches, plus extremes and full-range values
    function automatic logic signed [ale_pkg::VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            case ($urandom_range(0, 5))
                0: return 5;
                1: return -7;
                2: return 0;
                3: return 1000;
                4: return 32'sh7fffffff;
                default: return 32'sh80000000;
            endcase
        end
        if (r < 80) return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2: return -1;
            default: return 0;
        endcase
    endfunction

    initial
    begin
        int counted;
        int r;
        int ins_w;
        int del_w;
        int pos;
        int rot;
        logic [3:0] op;

        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        rsp_ch.ready   = 1'b0;
        shadow_len     = 0;
        plan_len       = 0;
        queued_total   = 0;
        accepted_total = 0;
        cycle_count    = 0;
        mismatches     = 0;
        beats_checked  = 0;
        n_ins = 0; n_del = 0; n_search = 0; n_list = 0; n_rot = 0; n_ignored = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty-list cases
        queue_cmd(ale_pkg::CMD_LIST, 0, 0, 0);
        queue_cmd(ale_pkg::CMD_DEL_FRONT, 0, 0, 0);
        queue_cmd(ale_pkg::CMD_DEL_END, 0, 0, 0);
        queue_cmd(ale_pkg::CMD_DEL_POS, 0, 3, 0);
        queue_cmd(ale_pkg::CMD_ROTATE, 0, 0, 0);
        queue_cmd(ale_pkg::CMD_SEARCH, 5, 0, 0);
        // position is ignored on an empty list
        queue_cmd(ale_pkg::CMD_INS_POS, 11, 200, 0);
        queue_cmd(ale_pkg::CMD_INS_END, 32'sh7fffffff, 0, 0);
        queue_cmd(ale_pkg::CMD_INS_FRONT, 32'sh80000000, 0, 0);
        queue_cmd(ale_pkg::CMD_INS_POS, 3, 0, 0);
        queue_cmd(ale_pkg::CMD_INS_POS, 3, 5, 0);
        queue_cmd(ale_pkg::CMD_INS_POS, -1, 4, 0);
        queue_cmd(ale_pkg::CMD_INS_POS, 5, 2, 0);
        queue_cmd(ale_pkg::CMD_INS_END, 5, 0, 0);
        queue_cmd(ale_pkg::CMD_INS_FRONT, 5, 0, 0);
        queue_cmd(ale_pkg::CMD_INS_POS, 0, 1, 0);
        // full list: position one reports full, a bad position reports range
        queue_cmd(ale_pkg::CMD_INS_END, 9, 0, 0);
        queue_cmd(ale_pkg::CMD_INS_POS, 9, 1, 0);
        queue_cmd(ale_pkg::CMD_INS_POS, 9, 255, 0);
        queue_cmd(ale_pkg::CMD_SEARCH, 5, 0, 0);
        queue_cmd(ale_pkg::CMD_LIST, 0, 0, 0);
        queue_cmd(ale_pkg::CMD_ROTATE, 0, 0, 7);
        queue_cmd(ale_pkg::CMD_ROTATE, 0, 0, 8);
        queue_cmd(ale_pkg::CMD_ROTATE, 0, 0, 0);
        queue_cmd(ale_pkg::CMD_DEL_POS, 0, 9, 255);
        queue_cmd(ale_pkg::CMD_DEL_POS, 0, 0, 0);
        queue_cmd(CMD_LAST_UNUSED, -1, 255, 255);
        queue_cmd(ale_pkg::CMD_DEL_POS, 0, 8, 0);
        queue_cmd(ale_pkg::CMD_DEL_END, 0, 0, 0);
        queue_cmd(ale_pkg::CMD_DEL_FRONT, 0, 0, 0);
        queue_cmd(CMD_FIRST_UNUSED, 0, 0, 0);
        wait_drained();

        counted = 0;
        while (counted < RAND_ITEMS)
        begin
            if (counted == RAND_ITEMS / 2)
                wait_drained();
            ins_w = (plan_len < 3) ? 50 : (plan_len >= 7) ? 20 : 35;
            del_w = (plan_len >= 7) ? 40 : 25;
            r   = $urandom_range(0, 99);
            pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                              : $urandom_range(0, plan_len + 2);
            rot = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                              : $urandom_range(0, plan_len);
            if (r < 3)
                op = 4'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
            else if (r < 3 + ins_w)
                op = 4'($urandom_range(ale_pkg::CMD_INS_FRONT, ale_pkg::CMD_INS_POS));
            else if (r < 3 + ins_w + del_w)
                op = 4'($urandom_range(ale_pkg::CMD_DEL_FRONT, ale_pkg::CMD_DEL_POS));
            else
                op = 4'($urandom_range(ale_pkg::CMD_SEARCH, ale_pkg::CMD_ROTATE));
            queue_cmd(op, pick_value(), pos, rot);
            if (op <= ale_pkg::CMD_ROTATE) counted++;
            // keep the pending queue short so the generator's length guess stays close
            while (pending_cmds.size() > 4) @(posedge clk);
        end
        wait_drained();

        $display("commands: %0d insert, %0d delete, %0d search, %0d list, %0d rotate, %0d ignored",
                 n_ins, n_del, n_search, n_list, n_rot, n_ignored);
        $display("%0d result beats checked, %0d mismatches, %0d cycles",
                 beats_checked, mismatches, cycle_count);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ----- array_list_engine_core.f -----
rtl/ale_pkg.sv
rtl/ale_cmd_if.sv
rtl/ale_res_if.sv
rtl/ale_store.sv
rtl/array_list_engine_core.sv
bench/tb_top.sv
